### rtl/mmcs_pkg.sv
package mmcs_pkg;

	// active pixel width; the pixel field itself is always PIX_W bits
	localparam int PIXEL_BITS = 16;
	localparam int PIX_W      = 16;

	// front/back queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// divider step counter
	localparam int CNT_W = $clog2(PIXEL_BITS);

	localparam logic KIND_MEASURE = 1'b0;
	localparam logic KIND_SCALE   = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] pixel;
		logic             last;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] scaled;
		logic             last_out;
		logic             flat_range;
	} out_item_t;

	typedef enum logic {
		OP_LATCH,
		OP_SCALE
	} op_t;

	// OP_LATCH: a = min, b = max. OP_SCALE: a = pixel, b unused.
	typedef struct packed {
		op_t                   op;
		logic [PIXEL_BITS-1:0] a;
		logic [PIXEL_BITS-1:0] b;
		logic                  last;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic {
		BK_IDLE,
		BK_DIV
	} back_state_t;

	typedef struct packed {
		logic dividing;
	} back_stat_t;

endpackage

### rtl/mmcs_queue.sv
module mmcs_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mmcs_pkg::q_entry_t wr_entry,
	input  logic               pop,
	output mmcs_pkg::q_entry_t rd_entry,
	output mmcs_pkg::q_stat_t  stat
);
	import mmcs_pkg::*;

	q_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign stat.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/mmcs_front.sv
module mmcs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mmcs_pkg::in_item_t item,
	input  mmcs_pkg::q_stat_t  q_stat,
	output logic               busy,
	output logic               push,
	output mmcs_pkg::q_entry_t entry
);
	import mmcs_pkg::*;

	logic [PIXEL_BITS-1:0] running_min_q;
	logic [PIXEL_BITS-1:0] running_max_q;
	logic [PIXEL_BITS-1:0] p;
	logic [PIXEL_BITS-1:0] lo;
	logic [PIXEL_BITS-1:0] hi;
	logic                  accept;

	assign busy   = q_stat.full;
	assign accept = start && !busy;
	assign p      = item.pixel[PIXEL_BITS-1:0];
	assign lo     = (p <= running_min_q) ? p : running_min_q;
	assign hi     = (p >= running_max_q) ? p : running_max_q;

	// measure beats only go to the queue when they close a frame
	assign push = accept && ((item.kind == KIND_SCALE) || item.last);

	always_comb begin
		entry.last = item.last;
		if (item.kind == KIND_SCALE) begin
			entry.op = OP_SCALE;
			entry.a  = p;
			entry.b  = '0;
		end else begin
			entry.op = OP_LATCH;
			entry.a  = lo;
			entry.b  = hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_min_q <= '1;
			running_max_q <= '0;
		end else if (accept && (item.kind == KIND_MEASURE)) begin
			if (item.last) begin
				running_min_q <= '1;
				running_max_q <= '0;
			end else begin
				running_min_q <= lo;
				running_max_q <= hi;
			end
		end
	end

endmodule

### rtl/mmcs_back.sv
module mmcs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mmcs_pkg::q_entry_t  entry,
	input  mmcs_pkg::q_stat_t   q_stat,
	output logic                pop,
	output mmcs_pkg::out_item_t result,
	output logic                done,
	output mmcs_pkg::back_stat_t stat
);
	import mmcs_pkg::*;

	localparam int PB = PIXEL_BITS;

	back_state_t   state_q, state_d;
	logic [PB-1:0] frame_min_q, frame_min_d;
	logic [PB-1:0] frame_max_q, frame_max_d;
	logic [PB-1:0] rem_q, rem_d;
	logic [PB-1:0] quo_q, quo_d;
	logic [PB-1:0] span_q, span_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic          last_q, last_d;
	out_item_t     out_q, out_d;
	logic          done_q, done_d;

	logic [PB-1:0]   diff;
	logic [2*PB-1:0] num;
	logic [PB:0]     shifted;
	logic [PB:0]     trial;

	assign pop           = !q_stat.empty && (state_q == BK_IDLE);
	assign result        = out_q;
	assign done          = done_q;
	assign stat.dividing = (state_q == BK_DIV);

	// FULL*d = (d << PB) - d; the top half is below span so PB quotient bits suffice
	assign diff    = entry.a - frame_min_q;
	assign num     = {diff, {PB{1'b0}}} - {{PB{1'b0}}, diff};
	assign shifted = {rem_q, quo_q[PB-1]};
	assign trial   = shifted - {1'b0, span_q};

	always_comb begin
		state_d     = state_q;
		frame_min_d = frame_min_q;
		frame_max_d = frame_max_q;
		rem_d       = rem_q;
		quo_d       = quo_q;
		span_d      = span_q;
		cnt_d       = cnt_q;
		last_d      = last_q;
		out_d       = out_q;
		done_d      = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (pop) begin
					if (entry.op == OP_LATCH) begin
						frame_min_d = entry.a;
						frame_max_d = entry.b;
					end else if (frame_max_q <= frame_min_q) begin
						out_d  = '{scaled: '0, last_out: entry.last, flat_range: 1'b1};
						done_d = 1'b1;
					end else if (entry.a <= frame_min_q) begin
						out_d  = '{scaled: '0, last_out: entry.last, flat_range: 1'b0};
						done_d = 1'b1;
					end else if (entry.a >= frame_max_q) begin
						out_d  = '{scaled: PIX_W'({PB{1'b1}}), last_out: entry.last,
							flat_range: 1'b0};
						done_d = 1'b1;
					end else begin
						rem_d   = num[2*PB-1:PB];
						quo_d   = num[PB-1:0];
						span_d  = frame_max_q - frame_min_q;
						cnt_d   = CNT_W'(PB-1);
						last_d  = entry.last;
						state_d = BK_DIV;
					end
				end
			end
			BK_DIV: begin
				if (!trial[PB]) begin
					rem_d = trial[PB-1:0];
				end else begin
					rem_d = shifted[PB-1:0];
				end
				quo_d = {quo_q[PB-2:0], !trial[PB]};
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0) begin
					out_d   = '{scaled: PIX_W'(quo_d), last_out: last_q, flat_range: 1'b0};
					done_d  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			frame_min_q <= '0;
			frame_max_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			frame_min_q <= frame_min_d;
			frame_max_q <= frame_max_d;
			done_q      <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= rem_d;
		quo_q  <= quo_d;
		span_q <= span_d;
		cnt_q  <= cnt_d;
		last_q <= last_d;
		out_q  <= out_d;
	end

endmodule

### rtl/minmax_contrast_stretch_16_top.sv
// Front: one beat per cycle while busy is low; measure beats end there but for a frame's
// last, which queues a latch op. Scale beats queue (4 deep); inside the range the back end
// divides them (one quotient bit per cycle) in BK_DIV and out_q registers the result,
// else the clamped result is out in the cycle after the pop. No entry is popped mid-divide.
// The receiver cannot stall: done pulses for one cycle per result.
// arst_n clears the queue, the running pair (min all ones, max zero) and the frame range.
module minmax_contrast_stretch_16_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  mmcs_pkg::in_item_t  item,
	output logic                busy,
	output mmcs_pkg::out_item_t result,
	output logic                done
);
	import mmcs_pkg::*;

	// front -> queue
	logic       push;
	q_entry_t   wr_entry;
	// queue -> back
	logic       pop;
	q_entry_t   rd_entry;
	q_stat_t    q_stat;
	back_stat_t b_stat;

	// front: accepts beats, tracks the running min/max, queues latch and scale ops
	mmcs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.q_stat (q_stat),
		.busy   (busy),
		.push   (push),
		.entry  (wr_entry)
	);

	// short queue keeps latch ops in order with the scale beats around them
	mmcs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.stat     (q_stat)
	);

	// back: owns the frame range, clamps and runs the bit-serial divide
	mmcs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.entry  (rd_entry),
		.q_stat (q_stat),
		.pop    (pop),
		.result (result),
		.done   (done),
		.stat   (b_stat)
	);

	// a flat range always yields zero
	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.flat_range) |-> (result.scaled == '0))
		else $error("flat range gave non-zero result");

	// nothing is pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("queue overflow");

	// no result leaves while the divider is mid-operation
	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.dividing |-> !done)
		else $error("result during divide");

	// the back end never pops while dividing
	a_no_pop_div: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.dividing |-> !pop)
		else $error("pop during divide");

endmodule

### dv/minmax_contrast_stretch_16_top_test.sv
`timescale 1ns / 100ps

module minmax_contrast_stretch_16_top_test;
	import mmcs_pkg::*;

	// slowest legal run is ~1300 beats x (divider + longest sender gap); this is far above that
	localparam int CYCLE_LIMIT = 500000;
	// queue depth times divider latency, with margin
	localparam int SETTLE_CYCLES = (QDEPTH + 2) * (PIXEL_BITS + 2);
	localparam logic [PIX_W-1:0] FULL = PIX_W'((1 << PIXEL_BITS) - 1);

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	in_item_t  item   = '0;
	logic      busy;
	out_item_t result;
	logic      done;

	// mirror of the block's range registers, reset values as after arst_n
	logic [PIX_W-1:0] run_lo = FULL;
	logic [PIX_W-1:0] run_hi = '0;
	logic [PIX_W-1:0] frm_lo = '0;
	logic [PIX_W-1:0] frm_hi = '0;

	out_item_t stretched_q[$];  // scaled pixels still owed by the block, oldest first
	int        errors     = 0;
	int        cycles     = 0;
	int        gap_pct    = 0;  // chance in 100 that the sender idles a cycle
	int        beats_sent = 0;

	minmax_contrast_stretch_16_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.result (result),
		.done   (done)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Update the range mirror for one accepted beat; a scale beat owes one result.
	function automatic void predict_stretch(input in_item_t b);
		logic [PIX_W-1:0] p, lo, hi;
		logic [63:0]      num;
		out_item_t        r;
		p = b.pixel & FULL;
		if (b.kind == KIND_MEASURE) begin
			lo = (p <= run_lo) ? p : run_lo;
			hi = (p >= run_hi) ? p : run_hi;
			if (b.last) begin
				// last beat closes the frame: range latched, running pair restarts
				frm_lo = lo;
				frm_hi = hi;
				run_lo = FULL;
				run_hi = '0;
			end else begin
				run_lo = lo;
				run_hi = hi;
			end
		end else begin
			r.last_out   = b.last;
			r.flat_range = (frm_hi <= frm_lo);
			if (r.flat_range || p <= frm_lo) begin
				r.scaled = '0;
			end else if (p >= frm_hi) begin
				r.scaled = FULL;
			end else begin
				num = 64'(FULL) * 64'(p - frm_lo);
				num = num / 64'(frm_hi - frm_lo);
				r.scaled = num[PIX_W-1:0];
			end
			stretched_q.push_back(r);
		end
	endfunction

	function automatic void compare_field(input string name, input logic [PIX_W-1:0] want,
			input logic [PIX_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// every done pulse must match the oldest outstanding scale beat
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && done) begin
			if (stretched_q.size() == 0) begin
				$error("unexpected result beat: scaled %0d", result.scaled);
				errors++;
			end else begin
				want = stretched_q.pop_front();
				compare_field("scaled", want.scaled, result.scaled);
				compare_field("last_out", PIX_W'(want.last_out), PIX_W'(result.last_out));
				compare_field("flat_range", PIX_W'(want.flat_range), PIX_W'(result.flat_range));
			end
		end
	end

	// Drive one beat at the falling edge, hold it until taken (start high, busy low).
	task automatic send_beat(input logic kind, input logic [PIX_W-1:0] pix, input logic lst);
		in_item_t b;
		b.kind  = kind;
		b.pixel = pix;
		b.last  = lst;
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_stretch(b);
		beats_sent++;
	endtask

	// sender goes quiet until every owed result has come back
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (stretched_q.size() != 0) @(posedge clk);
	endtask

	// nothing measured yet: range 0..0 is flat
	task automatic test_after_reset();
		send_beat(KIND_SCALE, 16'd0, 1'b0);
		send_beat(KIND_SCALE, 16'hFFFF, 1'b1);
	endtask

	task automatic test_directed_ranges();
		// full range, extremes either side of mid-scale
		send_beat(KIND_MEASURE, 16'hFFFF, 1'b0);
		send_beat(KIND_MEASURE, 16'd0, 1'b1);
		send_beat(KIND_SCALE, 16'd0, 1'b0);
		send_beat(KIND_SCALE, 16'hFFFF, 1'b0);
		send_beat(KIND_SCALE, 16'd1, 1'b0);
		send_beat(KIND_SCALE, 16'h8000, 1'b0);
		send_beat(KIND_SCALE, 16'hFFFE, 1'b1);
		// narrow range: below, above, both edges, one value inside
		send_beat(KIND_MEASURE, 16'd150, 1'b0);
		send_beat(KIND_MEASURE, 16'd100, 1'b0);
		send_beat(KIND_MEASURE, 16'd200, 1'b1);
		send_beat(KIND_SCALE, 16'd50, 1'b0);
		send_beat(KIND_SCALE, 16'd250, 1'b0);
		send_beat(KIND_SCALE, 16'd100, 1'b0);
		send_beat(KIND_SCALE, 16'd200, 1'b0);
		send_beat(KIND_SCALE, 16'd149, 1'b1);
		// one-pixel frame gives a flat range
		send_beat(KIND_MEASURE, 16'd7, 1'b1);
		send_beat(KIND_SCALE, 16'd7, 1'b0);
		send_beat(KIND_SCALE, 16'd0, 1'b1);
		// scale beat mid-measure still sees the old (flat) range; then span of one
		send_beat(KIND_MEASURE, 16'd1000, 1'b0);
		send_beat(KIND_SCALE, 16'd3, 1'b0);
		send_beat(KIND_MEASURE, 16'd1001, 1'b1);
		send_beat(KIND_SCALE, 16'd1000, 1'b0);
		send_beat(KIND_SCALE, 16'd1001, 1'b1);
	endtask

	// Mostly whole frames (measure pass then scale pass) over a random window,
	// with some noise beats and frames cut short before their last beat.
	task automatic test_random_frames(input int beats);
		int target, n, w, lo, hi, slo, shi;
		target = beats_sent + beats;
		while (beats_sent < target) begin
			case ($urandom_range(4))
				0:       w = 0;
				1:       w = $urandom_range(3);
				2:       w = $urandom_range(255);
				3:       w = $urandom_range(65535);
				default: w = 65535;
			endcase
			lo  = $urandom_range(65535 - w);
			hi  = lo + w;
			slo = lo - w / 4 - 1;
			shi = hi + w / 4 + 1;
			if (slo < 0) slo = 0;
			if (shi > 65535) shi = 65535;
			case ($urandom_range(9))
				0: begin
					n = $urandom_range(1, 4);
					repeat (n) send_beat(1'($urandom_range(1)), PIX_W'($urandom_range(65535)),
						1'($urandom_range(1)));
				end
				1: begin
					// measure pass that never closes: running pair carries over
					n = $urandom_range(1, 5);
					repeat (n) send_beat(KIND_MEASURE, PIX_W'($urandom_range(hi, lo)), 1'b0);
				end
				default: begin
					n = $urandom_range(1, 8);
					repeat (n - 1) send_beat(KIND_MEASURE, PIX_W'($urandom_range(hi, lo)),
						1'b0);
					send_beat(KIND_MEASURE, PIX_W'($urandom_range(hi, lo)), 1'b1);
					n = $urandom_range(1, 10);
					repeat (n - 1) send_beat(KIND_SCALE, PIX_W'($urandom_range(shi, slo)),
						1'b0);
					send_beat(KIND_SCALE, PIX_W'($urandom_range(shi, slo)), 1'b1);
				end
			endcase
		end
	endtask

	initial begin
		// reset held at start, released on a falling edge
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		gap_pct = 0;
		test_after_reset();
		test_directed_ranges();
		drain_results();

		gap_pct = 7;
		test_random_frames(430);
		drain_results();

		gap_pct = 83;
		test_random_frames(430);
		drain_results();

		// back to back: scale bursts fill the queue and push busy high
		gap_pct = 0;
		test_random_frames(440);
		drain_results();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### minmax_contrast_stretch_16_top.f
rtl/mmcs_pkg.sv
rtl/mmcs_queue.sv
rtl/mmcs_front.sv
rtl/mmcs_back.sv
rtl/minmax_contrast_stretch_16_top.sv
dv/minmax_contrast_stretch_16_top_test.sv
